// File: hw/rtl/blocking_message_queue_bank_top_assert.svh
// Assertion macros for the blocking message queue bank.
// Used by the top level; depends on nothing else.
`ifndef BLOCKING_MESSAGE_QUEUE_BANK_TOP_ASSERT_SVH
`define BLOCKING_MESSAGE_QUEUE_BANK_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BMQB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMQB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/bmqb_pkg.sv
// Shared types and codes of the blocking message queue bank.
// Used by bmqb_ring and blocking_message_queue_bank_top.
package bmqb_pkg;

   localparam int LW = 6;
   localparam logic [LW-1:0] NIL = 6'd63;

   localparam logic [2:0] ACT_CREATE  = 3'd0;
   localparam logic [2:0] ACT_DELETE  = 3'd1;
   localparam logic [2:0] ACT_SEND    = 3'd2;
   localparam logic [2:0] ACT_RECEIVE = 3'd3;
   localparam logic [2:0] ACT_RESET   = 3'd4;
   localparam logic [2:0] ACT_COUNT   = 3'd5;
   localparam logic [2:0] ACT_REQUEUE = 3'd6;
   localparam logic [2:0] ACT_CANCEL  = 3'd7;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BLOCKED     = 3'd1;
   localparam logic [2:0] ST_BAD_QUEUE   = 3'd2;
   localparam logic [2:0] ST_NONE_FREE   = 3'd3;
   localparam logic [2:0] ST_BAD_COUNT   = 3'd4;
   localparam logic [2:0] ST_WOKEN       = 3'd5;
   localparam logic [2:0] ST_NOT_WAITING = 3'd6;

   localparam logic [1:0] W_NONE = 2'd0;
   localparam logic [1:0] W_RECV = 2'd1;
   localparam logic [1:0] W_SEND = 2'd2;

   typedef enum logic [2:0] {
      RING_NOP, RING_CREATE, RING_CLEAR, RING_FREE, RING_PUSH, RING_POP
   } ring_op_type;

   typedef struct packed {
      ring_op_type  op;
      logic [5:0]   q;
      logic [6:0]   cap;
      logic [31:0]  data;
   } ring_cmd_type;

   typedef struct packed {
      logic [6:0] cap;
      logic [6:0] size;
   } ring_stat_type;

endpackage

// File: hw/rtl/bmqb_ring.sv
// Ring buffer pointers of all queues and the shared message slot memory.
// Depends on bmqb_pkg.
module bmqb_ring #(
   parameter int NUM_QUEUES = 16,
   parameter int MAX_DEPTH  = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bmqb_pkg::ring_cmd_type cmd,
   input  logic [5:0]             query_q,
   output bmqb_pkg::ring_stat_type stat,
   output logic [31:0]            rdata
);
   import bmqb_pkg::*;

   localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int AW  = (NUM_QUEUES * MAX_DEPTH > 1) ? $clog2(NUM_QUEUES * MAX_DEPTH) : 1;

   logic [6:0]  cap_ff   [NUM_QUEUES];
   logic [6:0]  front_ff [NUM_QUEUES];
   logic [6:0]  rear_ff  [NUM_QUEUES];
   logic [6:0]  size_ff  [NUM_QUEUES];
   logic [31:0] slot_mem [NUM_QUEUES * MAX_DEPTH];
   logic [31:0] rdata_ff;

   logic [QIW-1:0] qi, qq;
   logic [6:0]     rear_in, front_in;
   logic [AW-1:0]  waddr, raddr;

   assign qi = QIW'(cmd.q);
   assign qq = QIW'(query_q);
   assign stat.cap  = cap_ff[qq];
   assign stat.size = size_ff[qq];
   assign rdata = rdata_ff;

   assign rear_in  = (rear_ff[qi] + 7'd1 == cap_ff[qi]) ? 7'd0 : rear_ff[qi] + 7'd1;
   assign front_in = (front_ff[qi] + 7'd1 == cap_ff[qi]) ? 7'd0 : front_ff[qi] + 7'd1;
   assign waddr = AW'(int'(qi) * MAX_DEPTH + int'(rear_in));
   assign raddr = AW'(int'(qi) * MAX_DEPTH + int'(front_ff[qi]));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            cap_ff[i]   <= '0;
            front_ff[i] <= '0;
            rear_ff[i]  <= '0;
            size_ff[i]  <= '0;
         end
      end else begin
         unique case (cmd.op)
            RING_CREATE: begin
               cap_ff[qi]   <= cmd.cap;
               front_ff[qi] <= '0;
               rear_ff[qi]  <= cmd.cap - 7'd1;
               size_ff[qi]  <= '0;
            end
            RING_CLEAR: begin
               front_ff[qi] <= '0;
               rear_ff[qi]  <= cap_ff[qi] - 7'd1;
               size_ff[qi]  <= '0;
            end
            RING_FREE: cap_ff[qi] <= '0;
            RING_PUSH: begin
               rear_ff[qi] <= rear_in;
               size_ff[qi] <= size_ff[qi] + 7'd1;
            end
            RING_POP: begin
               front_ff[qi] <= front_in;
               size_ff[qi]  <= size_ff[qi] - 7'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == RING_PUSH) begin
         slot_mem[waddr] <= cmd.data;
      end
      if (cmd.op == RING_POP) begin
         rdata_ff <= slot_mem[raddr];
      end
   end

endmodule

// File: hw/rtl/blocking_message_queue_bank_top.sv
// Top level of the blocking message queue bank: command sequencer and wait lists.
// Depends on bmqb_pkg, bmqb_ring and the assertion macro header.
//
// A command is taken when start is high and busy is low; the block then stays
// busy until its reply, which is always the last result. Wake results come at
// most one per cycle before the reply. Results are shown for one cycle on
// rsp_strobe and cannot be held off. Priority insertion, removal from a list
// and count step through the list one entry a cycle (up to NUM_PROCS), create
// scans the queues one a cycle (up to NUM_QUEUES), and delete or reset wake
// the waiting processes one at a time, first the receivers and then the
// senders. A receive passes through S_POP_WAIT and S_POP_DATA for the
// registered read of the slot memory.
module blocking_message_queue_bank_top #(
   parameter int NUM_QUEUES = 16,
   parameter int MAX_DEPTH  = 64,
   parameter int NUM_PROCS  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [3:0]         req_queue_id,
   input  logic [6:0]         req_capacity,
   input  logic signed [31:0] req_message,
   input  logic [4:0]         req_process_id,
   input  logic [7:0]         req_priority_req,
   output logic               rsp_strobe,
   output logic               rsp_kind,
   output logic [2:0]         rsp_status,
   output logic [3:0]         rsp_new_queue,
   output logic signed [7:0]  rsp_count,
   output logic signed [31:0] rsp_delivered,
   output logic [4:0]         rsp_woken_process,
   output logic               rsp_last
);
   import bmqb_pkg::*;

   `include "blocking_message_queue_bank_top_assert.svh"

   localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SCAN, S_WAKE, S_UNLINK, S_UNLINK_WALK, S_UNLINKED,
      S_BLOCK, S_INS, S_INS_WALK, S_POP_WAIT, S_POP_DATA, S_REPLY_OK, S_LEN
   } state_type;

   state_type state_ff;

   logic [2:0]     act_ff;
   logic [3:0]     q_ff;
   logic [6:0]     cap_ff;
   logic [31:0]    msg_ff;
   logic [4:0]     pid_ff;
   logic [7:0]     prio_ff;
   logic [QIW-1:0] scan_ff;
   logic [QIW-1:0] lq_ff;
   logic           lk_ff;
   logic [LW-1:0]  cur_ff;
   logic [LW-1:0]  pnext_ff;
   logic [5:0]     len_ff;
   logic           full_ff;
   logic [31:0]    dlv_ff;

   logic [LW-1:0]  rhead_ff  [NUM_QUEUES];
   logic [LW-1:0]  shead_ff  [NUM_QUEUES];
   logic [LW-1:0]  wnext_ff  [NUM_PROCS];
   logic [7:0]     wprio_ff  [NUM_PROCS];
   logic [1:0]     wkind_ff  [NUM_PROCS];
   logic [QIW-1:0] wqueue_ff [NUM_PROCS];
   logic [31:0]    wmsg_ff   [NUM_PROCS];

   logic               rsp_strobe_ff, rsp_kind_ff, rsp_last_ff;
   logic [2:0]         rsp_status_ff;
   logic [3:0]         rsp_new_queue_ff;
   logic [7:0]         rsp_count_ff;
   logic [31:0]        rsp_delivered_ff;
   logic [4:0]         rsp_woken_ff;

   ring_cmd_type  ring_cmd_ff;
   ring_stat_type stat;
   logic [31:0]   ring_rdata;
   logic [5:0]    query_q;

   logic [QIW-1:0] qidx;
   logic [PW-1:0]  pidx;
   logic           pid_ok, q_ok, q_valid, is_send, blocking;
   logic [LW-1:0]  head_cur, nxt;
   logic [7:0]     sum8, cnt_pos, cnt_neg;

   bmqb_ring #(.NUM_QUEUES(NUM_QUEUES), .MAX_DEPTH(MAX_DEPTH)) u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd_ff),
      .query_q (query_q),
      .stat    (stat),
      .rdata   (ring_rdata)
   );

   assign qidx     = QIW'(q_ff);
   assign pidx     = PW'(pid_ff);
   assign pid_ok   = int'(pid_ff) < NUM_PROCS;
   assign q_ok     = int'(q_ff) < NUM_QUEUES;
   assign query_q  = (state_ff == S_SCAN) ? 6'(scan_ff) : 6'(qidx);
   assign q_valid  = q_ok && (stat.cap != 7'd0);
   assign is_send  = (act_ff == ACT_SEND);
   assign blocking = is_send ? (stat.size == stat.cap) : (stat.size == 7'd0);
   assign head_cur = lk_ff ? shead_ff[lq_ff] : rhead_ff[lq_ff];
   assign nxt      = wnext_ff[PW'(cur_ff)];

   assign sum8    = {1'b0, stat.size} + {2'b00, len_ff};
   assign cnt_pos = (sum8 > 8'd127) ? 8'd127 : sum8;
   assign cnt_neg = 8'd0 - {2'b00, len_ff};

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_new_queue     = rsp_new_queue_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_delivered     = rsp_delivered_ff;
   assign rsp_woken_process = rsp_woken_ff;
   assign rsp_last          = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         ring_cmd_ff   <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            rhead_ff[i] <= NIL;
            shead_ff[i] <= NIL;
         end
         for (int i = 0; i < NUM_PROCS; i++) begin
            wnext_ff[i] <= NIL;
            wkind_ff[i] <= W_NONE;
         end
      end else begin
         rsp_strobe_ff    <= 1'b0;
         rsp_kind_ff      <= 1'b0;
         rsp_last_ff      <= 1'b0;
         rsp_status_ff    <= ST_OK;
         rsp_new_queue_ff <= '0;
         rsp_count_ff     <= '0;
         rsp_delivered_ff <= '0;
         rsp_woken_ff     <= '0;
         ring_cmd_ff.op   <= RING_NOP;

         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff   <= req_action;
                  q_ff     <= req_queue_id;
                  cap_ff   <= req_capacity;
                  msg_ff   <= req_message;
                  pid_ff   <= req_process_id;
                  prio_ff  <= req_priority_req;
                  dlv_ff   <= '0;
                  state_ff <= S_DECODE;
               end
            end

            S_DECODE: begin
               ring_cmd_ff.q <= 6'(qidx);
               unique case (act_ff)
                  ACT_CREATE: begin
                     if (cap_ff == 7'd0 || int'(cap_ff) > MAX_DEPTH) begin
                        rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                        rsp_status_ff <= ST_BAD_COUNT; state_ff <= S_IDLE;
                     end else begin
                        scan_ff  <= '0;
                        state_ff <= S_SCAN;
                     end
                  end
                  ACT_DELETE, ACT_RESET: begin
                     if (!q_valid) begin
                        rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                        rsp_status_ff <= ST_BAD_QUEUE; state_ff <= S_IDLE;
                     end else begin
                        ring_cmd_ff.op <= (act_ff == ACT_DELETE) ? RING_FREE : RING_CLEAR;
                        lq_ff    <= qidx;
                        lk_ff    <= 1'b0;
                        state_ff <= S_WAKE;
                     end
                  end
                  ACT_SEND, ACT_RECEIVE: begin
                     if (!q_valid) begin
                        rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                        rsp_status_ff <= ST_BAD_QUEUE; state_ff <= S_IDLE;
                     end else if (pid_ok && wkind_ff[pidx] != W_NONE) begin
                        // Withdraw the caller's current wait before going on.
                        lq_ff    <= wqueue_ff[pidx];
                        lk_ff    <= (wkind_ff[pidx] == W_SEND);
                        pnext_ff <= wnext_ff[pidx];
                        state_ff <= S_UNLINK;
                     end else begin
                        state_ff <= S_BLOCK;
                     end
                  end
                  ACT_COUNT: begin
                     if (!q_valid) begin
                        rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                        rsp_status_ff <= ST_BAD_QUEUE; state_ff <= S_IDLE;
                     end else begin
                        cur_ff   <= (stat.size == 7'd0) ? rhead_ff[qidx] : shead_ff[qidx];
                        len_ff   <= '0;
                        state_ff <= S_LEN;
                     end
                  end
                  default: begin
                     if (!pid_ok || (wkind_ff[pidx] != W_RECV && wkind_ff[pidx] != W_SEND)) begin
                        rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                        rsp_status_ff <= ST_NOT_WAITING; state_ff <= S_IDLE;
                     end else begin
                        lq_ff    <= wqueue_ff[pidx];
                        lk_ff    <= (wkind_ff[pidx] == W_SEND);
                        pnext_ff <= wnext_ff[pidx];
                        state_ff <= S_UNLINK;
                     end
                  end
               endcase
            end

            S_SCAN: begin
               if (stat.cap == 7'd0) begin
                  ring_cmd_ff.op  <= RING_CREATE;
                  ring_cmd_ff.q   <= 6'(scan_ff);
                  ring_cmd_ff.cap <= cap_ff;
                  rsp_strobe_ff    <= 1'b1; rsp_last_ff <= 1'b1;
                  rsp_new_queue_ff <= 4'(scan_ff);
                  state_ff         <= S_IDLE;
               end else if (int'(scan_ff) == NUM_QUEUES - 1) begin
                  rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                  rsp_status_ff <= ST_NONE_FREE; state_ff <= S_IDLE;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end

            S_WAKE: begin
               if (head_cur != NIL) begin
                  rsp_strobe_ff <= 1'b1; rsp_kind_ff <= 1'b1;
                  rsp_status_ff <= ST_WOKEN;
                  rsp_woken_ff  <= 5'(head_cur);
                  if (lk_ff) shead_ff[lq_ff] <= wnext_ff[PW'(head_cur)];
                  else       rhead_ff[lq_ff] <= wnext_ff[PW'(head_cur)];
                  wnext_ff[PW'(head_cur)] <= NIL;
                  wkind_ff[PW'(head_cur)] <= W_NONE;
               end else if (!lk_ff) begin
                  lk_ff <= 1'b1;
               end else begin
                  rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end

            S_UNLINK: begin
               if (head_cur == 6'(pid_ff)) begin
                  if (lk_ff) shead_ff[lq_ff] <= pnext_ff;
                  else       rhead_ff[lq_ff] <= pnext_ff;
                  wnext_ff[pidx] <= NIL;
                  state_ff       <= S_UNLINKED;
               end else begin
                  cur_ff   <= head_cur;
                  state_ff <= S_UNLINK_WALK;
               end
            end

            S_UNLINK_WALK: begin
               if (cur_ff == NIL) begin
                  wnext_ff[pidx] <= NIL;
                  state_ff       <= S_UNLINKED;
               end else if (nxt == 6'(pid_ff)) begin
                  wnext_ff[PW'(cur_ff)] <= pnext_ff;
                  wnext_ff[pidx]        <= NIL;
                  state_ff              <= S_UNLINKED;
               end else begin
                  cur_ff <= nxt;
               end
            end

            S_UNLINKED: begin
               priority if (act_ff == ACT_REQUEUE) begin
                  wprio_ff[pidx] <= prio_ff;
                  state_ff       <= S_INS;
               end else if (act_ff == ACT_CANCEL) begin
                  wkind_ff[pidx] <= W_NONE;
                  rsp_strobe_ff  <= 1'b1; rsp_last_ff <= 1'b1;
                  state_ff       <= S_IDLE;
               end else begin
                  wkind_ff[pidx] <= W_NONE;
                  state_ff       <= S_BLOCK;
               end
            end

            S_BLOCK: begin
               ring_cmd_ff.q <= 6'(qidx);
               if (blocking) begin
                  if (!pid_ok) begin
                     rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                     rsp_status_ff <= ST_NONE_FREE; state_ff <= S_IDLE;
                  end else begin
                     wkind_ff[pidx]  <= is_send ? W_SEND : W_RECV;
                     wqueue_ff[pidx] <= qidx;
                     wprio_ff[pidx]  <= prio_ff;
                     wmsg_ff[pidx]   <= is_send ? msg_ff : 32'd0;
                     lq_ff           <= qidx;
                     lk_ff           <= is_send;
                     state_ff        <= S_INS;
                  end
               end else if (is_send) begin
                  if (stat.size == 7'd0 && rhead_ff[qidx] != NIL) begin
                     // Direct handover to the first waiting receiver.
                     rsp_strobe_ff    <= 1'b1; rsp_kind_ff <= 1'b1;
                     rsp_woken_ff     <= 5'(rhead_ff[qidx]);
                     rsp_delivered_ff <= msg_ff;
                     rhead_ff[qidx]   <= wnext_ff[PW'(rhead_ff[qidx])];
                     wnext_ff[PW'(rhead_ff[qidx])] <= NIL;
                     wkind_ff[PW'(rhead_ff[qidx])] <= W_NONE;
                     state_ff         <= S_REPLY_OK;
                  end else begin
                     ring_cmd_ff.op   <= RING_PUSH;
                     ring_cmd_ff.data <= msg_ff;
                     rsp_strobe_ff    <= 1'b1; rsp_last_ff <= 1'b1;
                     state_ff         <= S_IDLE;
                  end
               end else begin
                  ring_cmd_ff.op <= RING_POP;
                  full_ff        <= (stat.size == stat.cap);
                  state_ff       <= S_POP_WAIT;
               end
            end

            S_INS: begin
               if (head_cur == NIL || wprio_ff[pidx] > wprio_ff[PW'(head_cur)]) begin
                  wnext_ff[pidx] <= head_cur;
                  if (lk_ff) shead_ff[lq_ff] <= 6'(pid_ff);
                  else       rhead_ff[lq_ff] <= 6'(pid_ff);
                  rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                  rsp_status_ff <= (act_ff == ACT_REQUEUE) ? ST_OK : ST_BLOCKED;
                  state_ff      <= S_IDLE;
               end else begin
                  cur_ff   <= head_cur;
                  state_ff <= S_INS_WALK;
               end
            end

            S_INS_WALK: begin
               if (nxt != NIL && wprio_ff[pidx] <= wprio_ff[PW'(nxt)]) begin
                  cur_ff <= nxt;
               end else begin
                  wnext_ff[pidx]        <= nxt;
                  wnext_ff[PW'(cur_ff)] <= 6'(pid_ff);
                  rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                  rsp_status_ff <= (act_ff == ACT_REQUEUE) ? ST_OK : ST_BLOCKED;
                  state_ff      <= S_IDLE;
               end
            end

            S_POP_WAIT: state_ff <= S_POP_DATA;

            S_POP_DATA: begin
               ring_cmd_ff.q <= 6'(qidx);
               if (full_ff && shead_ff[qidx] != NIL) begin
                  // The freed slot takes the message of the first waiting sender.
                  dlv_ff           <= ring_rdata;
                  ring_cmd_ff.op   <= RING_PUSH;
                  ring_cmd_ff.data <= wmsg_ff[PW'(shead_ff[qidx])];
                  rsp_strobe_ff    <= 1'b1; rsp_kind_ff <= 1'b1;
                  rsp_woken_ff     <= 5'(shead_ff[qidx]);
                  shead_ff[qidx]   <= wnext_ff[PW'(shead_ff[qidx])];
                  wnext_ff[PW'(shead_ff[qidx])] <= NIL;
                  wkind_ff[PW'(shead_ff[qidx])] <= W_NONE;
                  state_ff         <= S_REPLY_OK;
               end else begin
                  rsp_strobe_ff    <= 1'b1; rsp_last_ff <= 1'b1;
                  rsp_delivered_ff <= ring_rdata;
                  state_ff         <= S_IDLE;
               end
            end

            S_REPLY_OK: begin
               rsp_strobe_ff    <= 1'b1; rsp_last_ff <= 1'b1;
               rsp_delivered_ff <= dlv_ff;
               state_ff         <= S_IDLE;
            end

            S_LEN: begin
               if (cur_ff != NIL) begin
                  cur_ff <= nxt;
                  len_ff <= len_ff + 6'd1;
               end else begin
                  rsp_strobe_ff <= 1'b1; rsp_last_ff <= 1'b1;
                  rsp_count_ff  <= (stat.size == 7'd0) ? cnt_neg : cnt_pos;
                  state_ff      <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BMQB_ASSERT_NOW(a_reply_ends_cmd, clock, reset, rsp_strobe && rsp_last, !busy, "reply while busy")
   `BMQB_ASSERT_NOW(a_wake_not_last, clock, reset, rsp_strobe && rsp_kind, !rsp_last && busy, "wake marked last")
   `BMQB_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "command not taken")

endmodule
